// ===== src/rau_pkg.sv =====
package rau_pkg;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_LT  = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZDEN = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;
   localparam logic [1:0] ST_OVF  = 2'd3;

   localparam logic [63:0] LIM31 = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               is_less;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_GSTART, S_GCD,
      S_DNSTART, S_DIVN, S_DDSTART, S_DIVD, S_CHECK, S_OUT
   } state_type;

   typedef enum logic [2:0] {
      G_IDLE, G_EVEN, G_ODDX, G_LOOP, G_FIN
   } gcd_state_type;

endpackage

// ===== src/rau_gcd.sv =====
module rau_gcd
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic        done,
   output logic [63:0] g
);

   gcd_state_type state_ff, state_in;
   logic [63:0] x_ff, x_in, y_ff, y_in;
   logic [5:0]  sh_ff, sh_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               if (x == 64'd0 || y == 64'd0) state_in = G_FIN;
               else state_in = G_EVEN;
            end
         end
         G_EVEN: if (x_ff[0] || y_ff[0]) state_in = G_ODDX;
         G_ODDX: if (x_ff[0]) state_in = G_LOOP;
         G_LOOP: if (y_ff == 64'd0) state_in = G_FIN;
         G_FIN:  state_in = G_IDLE;
         default: state_in = G_IDLE;
      endcase
   end

   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      sh_in = sh_ff;
      unique case (state_ff)
         G_IDLE: begin
            sh_in = 6'd0;
            x_in  = (x == 64'd0) ? y : x;
            y_in  = y;
         end
         G_EVEN: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in  = x_ff >> 1;
               y_in  = y_ff >> 1;
               sh_in = sh_ff + 6'd1;
            end
         end
         G_ODDX: if (!x_ff[0]) x_in = x_ff >> 1;
         G_LOOP: begin
            if (y_ff != 64'd0) begin
               if (!y_ff[0]) y_in = y_ff >> 1;
               else if (x_ff > y_ff) begin
                  x_in = y_ff;
                  y_in = x_ff - y_ff;
               end else begin
                  y_in = y_ff - x_ff;
               end
            end
         end
         G_FIN: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= G_IDLE;
      else state_ff <= state_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      sh_ff <= sh_in;
   end

   assign done = (state_ff == G_FIN);
   assign g    = x_ff << sh_ff;

endmodule

// ===== src/rau_div.sv =====
module rau_div
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [64:0] shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd63;
         rem_in  = 64'd0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = 64'(shifted - {1'b0, dsr_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// fractions, result reduced to lowest terms with a positive denominator.
// Request: drive req_data and raise start; the beat is taken on a rising edge
// with start high and busy low. busy then stays high until the result is out.
// Response: rsp_data is valid for exactly one cycle while rsp_strobe is high.
// The receiver cannot stall; the result must be taken in that cycle.
// Zero denominator, divide by zero and unused commands skip all arithmetic;
// less-than stops after the products. Other commands take three passes of
// one shared 32x32 multiplier, a binary GCD loop on 64-bit values (one shift
// or one subtract per cycle) and two 64-bit restoring divisions by the GCD
// through one shared divider; a zero result skips the GCD and divisions.
// One item at a time; the next may start the cycle after rsp_strobe.
// Reset is synchronous and active high: it returns the sequencer to idle,
// drops busy and rsp_strobe, and drops any item in progress.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic        sa_ff, sa_in, sb_ff, sb_in, rneg_ff, rneg_in;
   logic [63:0] t1_ff, t1_in, t2_ff, t2_in, rd_ff, rd_in, rn_ff, rn_in;
   logic [63:0] g_ff, g_in, qn_ff, qn_in, qd_ff, qd_in;
   rsp_type     rsp_ff, rsp_in;

   logic [31:0] mul_a, mul_b, an_m, ad_m, bn_m, bd_m;
   logic [63:0] prod;
   logic        s2, early, accept;
   logic        gcd_done, div_done;
   logic [63:0] gcd_g, div_q, div_dividend;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

   assign accept = start && (state_ff == S_IDLE);
   assign an_m   = mag32(req_data.a_num);
   assign ad_m   = mag32(req_data.a_den);
   assign bn_m   = mag32(req_data.b_num);
   assign bd_m   = mag32(req_data.b_den);
   assign early  = (ad_m == 32'd0) || (bd_m == 32'd0) || (req_data.cmd > CMD_LT) ||
                   (req_data.cmd == CMD_DIV && bn_m == 32'd0);

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      unique case (state_ff)
         S_MUL0: begin
            mul_a = an_ff;
            mul_b = (cmd_ff == CMD_MUL) ? bn_ff : bd_ff;
         end
         S_MUL1: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         S_MUL2: begin
            mul_a = ad_ff;
            mul_b = (cmd_ff == CMD_DIV) ? bn_ff : bd_ff;
         end
         default: ;
      endcase
      prod = 64'(mul_a) * 64'(mul_b);
   end

   assign s2 = (t2_ff == 64'd0) ? 1'b0 : ((cmd_ff == CMD_SUB) ? !sb_ff : sb_ff);
   assign div_dividend = (state_ff == S_DDSTART) ? rd_ff : rn_ff;

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_GSTART),
      .x     (rn_ff),
      .y     (rd_ff),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DNSTART || state_ff == S_DDSTART),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (accept) state_in = early ? S_OUT : S_MUL0;
         S_MUL0:    state_in = S_MUL1;
         S_MUL1:    state_in = S_MUL2;
         S_MUL2:    state_in = S_COMB;
         S_COMB:    state_in = (cmd_ff == CMD_LT || rn_in == 64'd0) ? S_OUT : S_GSTART;
         S_GSTART:  state_in = S_GCD;
         S_GCD:     if (gcd_done) state_in = S_DNSTART;
         S_DNSTART: state_in = S_DIVN;
         S_DIVN:    if (div_done) state_in = S_DDSTART;
         S_DDSTART: state_in = S_DIVD;
         S_DIVD:    if (div_done) state_in = S_CHECK;
         S_CHECK:   state_in = S_OUT;
         S_OUT:     state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in  = cmd_ff;
      an_in   = an_ff;
      ad_in   = ad_ff;
      bn_in   = bn_ff;
      bd_in   = bd_ff;
      sa_in   = sa_ff;
      sb_in   = sb_ff;
      t1_in   = t1_ff;
      t2_in   = t2_ff;
      rd_in   = rd_ff;
      rn_in   = rn_ff;
      rneg_in = rneg_ff;
      g_in    = g_ff;
      qn_in   = qn_ff;
      qd_in   = qd_ff;
      rsp_in  = rsp_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd_in = req_data.cmd;
            an_in  = an_m;
            ad_in  = ad_m;
            bn_in  = bn_m;
            bd_in  = bd_m;
            sa_in  = (an_m != 32'd0) && (req_data.a_num[31] != req_data.a_den[31]);
            sb_in  = (bn_m != 32'd0) && (req_data.b_num[31] != req_data.b_den[31]);
            rsp_in = '{res_num: 32'sd0, res_den: 31'd1, is_less: 1'b0, status: ST_OK};
            if (ad_m == 32'd0 || bd_m == 32'd0) begin
               rsp_in.res_den = 31'd0;
               rsp_in.status  = ST_ZDEN;
            end else if (req_data.cmd == CMD_DIV && bn_m == 32'd0) begin
               rsp_in.res_den = 31'd0;
               rsp_in.status  = ST_DIV0;
            end
         end
         S_MUL0: t1_in = prod;
         S_MUL1: t2_in = prod;
         S_MUL2: rd_in = prod;
         S_COMB: begin
            rsp_in = '{res_num: 32'sd0, res_den: 31'd1, is_less: 1'b0, status: ST_OK};
            if (cmd_ff == CMD_LT) begin
               if (sa_ff != sb_ff) rsp_in.is_less = sa_ff;
               else if (sa_ff) rsp_in.is_less = (t1_ff > t2_ff);
               else rsp_in.is_less = (t1_ff < t2_ff);
            end else if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) begin
               rn_in   = t1_ff;
               rneg_in = sa_ff ^ sb_ff;
            end else if (sa_ff == s2) begin
               rn_in   = t1_ff + t2_ff;
               rneg_in = sa_ff;
            end else if (t1_ff >= t2_ff) begin
               rn_in   = t1_ff - t2_ff;
               rneg_in = sa_ff;
            end else begin
               rn_in   = t2_ff - t1_ff;
               rneg_in = s2;
            end
         end
         S_GCD:  if (gcd_done) g_in = gcd_g;
         S_DIVN: if (div_done) qn_in = div_q;
         S_DIVD: if (div_done) qd_in = div_q;
         S_CHECK: begin
            if (qd_ff >= LIM31 || qn_ff > LIM31 || (!rneg_ff && qn_ff == LIM31)) begin
               rsp_in = '{res_num: 32'sd0, res_den: 31'd0, is_less: 1'b0, status: ST_OVF};
            end else begin
               rsp_in.res_num = rneg_ff ? (32'd0 - qn_ff[31:0]) : qn_ff[31:0];
               rsp_in.res_den = qd_ff[30:0];
               rsp_in.is_less = 1'b0;
               rsp_in.status  = ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      cmd_ff  <= cmd_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      rd_ff   <= rd_in;
      rn_ff   <= rn_in;
      rneg_ff <= rneg_in;
      g_ff    <= g_in;
      qn_ff   <= qn_in;
      qd_ff   <= qd_in;
      rsp_ff  <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = (state_ff == S_OUT);
   assign rsp_data   = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted beat did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy) else $error("result beat not single");

   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_OK |-> rsp_data.res_den != 31'd0)
      else $error("ok result with zero denominator");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |-> rsp_data.res_num == 32'sd0)
      else $error("failed result with nonzero numerator");

endmodule

// ===== tb/tb_rational_arithmetic_unit.sv =====
module tb_rational_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type pending_ops[$];
   rsp_type expected_results[$];
   int      fail_count;
   int      idle_cycles;
   bit      calm_stretch;
   bit      hold_for_drain;
   logic    busy_at_edge;
   logic    taken;

   rational_arithmetic_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void split_mag(input logic [31:0] v, output bit neg,
                                     output logic [63:0] mag);
      neg = v[31];
      mag = neg ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
   endfunction

   function automatic logic [63:0] binary_gcd(input logic [63:0] x_in,
                                              input logic [63:0] y_in);
      logic [63:0] x;
      logic [63:0] y;
      logic [63:0] t;
      int          sh;
      x = x_in;
      y = y_in;
      sh = 0;
      if (x == 0) return y;
      if (y == 0) return x;
      while (((x | y) & 64'd1) == 0) begin
         x = x >> 1;
         y = y >> 1;
         sh++;
      end
      while ((x & 64'd1) == 0) x = x >> 1;
      while (y != 0) begin
         while ((y & 64'd1) == 0) y = y >> 1;
         if (x > y) begin
            t = x;
            x = y;
            y = t;
         end
         y = y - x;
      end
      return x << sh;
   endfunction

   function automatic rsp_type reduce_fraction(input req_type op);
      rsp_type r;
      bit an_neg, ad_neg, bn_neg, bd_neg, sa, sb, s2, rneg;
      logic [63:0] an, ad, bn, bd, rn, rd, t1, t2, g;
      logic signed [63:0] lhs, rhs;
      split_mag(op.a_num, an_neg, an);
      split_mag(op.a_den, ad_neg, ad);
      split_mag(op.b_num, bn_neg, bn);
      split_mag(op.b_den, bd_neg, bd);
      r = '0;
      if (ad == 0 || bd == 0) begin
         r.status = ST_ZDEN;
         return r;
      end
      r.res_den = 31'd1;
      if (op.cmd > CMD_LT) return r;
      sa = (an != 0) && (an_neg != ad_neg);
      sb = (bn != 0) && (bn_neg != bd_neg);
      if (op.cmd == CMD_LT) begin
         lhs = an * bd;
         rhs = bn * ad;
         if (sa) lhs = -lhs;
         if (sb) rhs = -rhs;
         r.is_less = lhs < rhs;
         return r;
      end
      if (op.cmd == CMD_DIV && bn == 0) begin
         r.res_den = '0;
         r.status = ST_DIV0;
         return r;
      end
      if (op.cmd == CMD_MUL) begin
         rn = an * bn;
         rd = ad * bd;
         rneg = sa != sb;
      end else if (op.cmd == CMD_DIV) begin
         rn = an * bd;
         rd = ad * bn;
         rneg = sa != sb;
      end else begin
         t1 = an * bd;
         t2 = bn * ad;
         s2 = (op.cmd == CMD_SUB) ? !sb : sb;
         if (t2 == 0) s2 = 1'b0;
         rd = ad * bd;
         if (sa == s2) begin
            rn = t1 + t2;
            rneg = sa;
         end else if (t1 >= t2) begin
            rn = t1 - t2;
            rneg = sa;
         end else begin
            rn = t2 - t1;
            rneg = s2;
         end
      end
      if (rn == 0) return r;
      g = binary_gcd(rn, rd);
      rn = rn / g;
      rd = rd / g;
      if (rd >= LIM31 || rn > LIM31 || (!rneg && rn == LIM31)) begin
         r.res_den = '0;
         r.status = ST_OVF;
         return r;
      end
      r.res_num = rneg ? -rn[31:0] : rn[31:0];
      r.res_den = rd[30:0];
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'($signed($urandom_range(0, 20)) - 10);
         1: return $urandom;
         2: return 32'($urandom_range(0, 1000)) * 32'($urandom_range(1, 50));
         3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3))}
                   ^ ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0);
         4: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return 32'd1 << $urandom_range(0, 31);
      endcase
   endfunction

   function automatic req_type make_op(input logic [2:0] cmd, input logic [31:0] an,
                                       input logic [31:0] ad, input logic [31:0] bn,
                                       input logic [31:0] bd);
      req_type op;
      op.cmd = cmd;
      op.a_num = an;
      op.a_den = ad;
      op.b_num = bn;
      op.b_den = bd;
      return op;
   endfunction

   initial begin
      req_type op;
      logic [31:0] den_a;
      logic [31:0] den_b;
      reset = 1'b1;
      fail_count = 0;
      hold_for_drain = 1'b0;
      pending_ops.push_back(make_op(CMD_ADD, 1, 2, 1, 3));
      pending_ops.push_back(make_op(CMD_SUB, 1, 2, 1, 2));
      pending_ops.push_back(make_op(CMD_MUL, -3, 4, 8, -9));
      pending_ops.push_back(make_op(CMD_DIV, 5, 7, -10, 21));
      pending_ops.push_back(make_op(CMD_LT, -1, 3, 1, 3));
      pending_ops.push_back(make_op(CMD_LT, 2, 3, 1, 3));
      pending_ops.push_back(make_op(CMD_ADD, 1, 0, 1, 1));
      pending_ops.push_back(make_op(CMD_LT, 1, 1, 1, 0));
      pending_ops.push_back(make_op(CMD_DIV, 1, 2, 0, 5));
      pending_ops.push_back(make_op(3'd5, 1, 2, 3, 4));
      pending_ops.push_back(make_op(3'd7, 9, 9, 9, 9));
      pending_ops.push_back(make_op(CMD_MUL, 32'h8000_0000, 1, -1, 1));
      pending_ops.push_back(make_op(CMD_MUL, 32'h8000_0000, 1, 1, 1));
      pending_ops.push_back(make_op(CMD_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1));
      pending_ops.push_back(make_op(CMD_DIV, 1, 32'h8000_0000, 1, 32'h7FFF_FFFF));
      pending_ops.push_back(make_op(CMD_SUB, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000, 32'hFFFF_FFFF));
      pending_ops.push_back(make_op(CMD_LT, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1));
      pending_ops.push_back(make_op(CMD_ADD, 0, -5, 0, 7));
      pending_ops.push_back(make_op(CMD_MUL, 0, 32'h8000_0000, 3, 3));
      pending_ops.push_back(make_op(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1));
      for (int i = 0; i < 600; i++) begin
         den_a = rand_operand();
         den_b = rand_operand();
         if ($urandom_range(0, 19) != 0 && den_a == 0) den_a = 1;
         if ($urandom_range(0, 19) != 0 && den_b == 0) den_b = 1;
         op = make_op($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4)),
                      rand_operand(), den_a, rand_operand(), den_b);
         pending_ops.push_back(op);
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_ops.size() == 300);
      hold_for_drain = 1'b1;
      wait (expected_results.size() == 0 && !start);
      hold_for_drain = 1'b0;
      wait (pending_ops.size() == 0 && !start);
      wait (expected_results.size() == 0);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      start = 1'b0;
      req_data = '0;
      calm_stretch = 1'b0;
   end

   always @(negedge clock) begin
      calm_stretch <= ($time / 20 > 40000 && $time / 20 < 60000);
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy_at_edge) begin
         if (pending_ops.size() != 0 && !hold_for_drain
             && (calm_stretch || $urandom_range(0, 99) >= 25)) begin
            req_data <= pending_ops.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (pending_ops.size() != 0 && !hold_for_drain
             && (calm_stretch || $urandom_range(0, 99) >= 25)) begin
            req_data <= pending_ops.pop_front();
            start <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      busy_at_edge <= reset ? 1'b1 : busy;
      taken = !reset && start && !busy;
      if (taken) expected_results.push_back(reduce_fraction(req_data));
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count++;
            end else if (rsp_data !== expected_results[0]) begin
               $display("%0t: mismatch expected %p actual %p", $time,
                        expected_results[0], rsp_data);
               fail_count++;
               void'(expected_results.pop_front());
            end else begin
               void'(expected_results.pop_front());
            end
         end
         if (taken || rsp_strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

endmodule
